/* hw/rtl/utf8d_pkg.sv */
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared widths, types and helpers of the UTF-8 decoder and classifier.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned REM_W   = 2;
  localparam int unsigned TDATA_W = 24;
  localparam int unsigned TUSER_W = 5;

  localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

  // lead byte kinds
  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_kind_t;

  // one finished character from the decoder
  typedef struct packed {
    logic             emit;
    logic [CP_W-1:0]  cp;
    logic [LEN_W-1:0] len;
    logic             single;   // one-byte character
    logic             cont_ok;  // every continuation byte was 10xxxxxx
    logic             bad;      // illegal lead byte
  } char_t;

  // classified result
  typedef struct packed {
    logic [CP_W-1:0]  cp;
    logic [LEN_W-1:0] len;
    logic             ws;
    logic             ascii;
    logic             latin;
    logic             digit;
    logic             bad;
  } result_t;

  function automatic lead_kind_t lead_kind(input logic [BYTE_W-1:0] b);
    lead_kind_t k;
    k = LEAD_BAD;
    if (b inside {[8'h00:8'h7F]}) k = LEAD_ASCII;
    else if (b inside {[8'hC0:8'hDF]}) k = LEAD_TWO;
    else if (b inside {[8'hE0:8'hEF]}) k = LEAD_THREE;
    else if (b inside {[8'hF0:8'hF7]}) k = LEAD_FOUR;
    return k;
  endfunction

  function automatic logic [LEN_W-1:0] shortest_len(input logic [CP_W-1:0] cp);
    logic [LEN_W-1:0] n;
    if (cp < 21'h00080)      n = LEN_ONE;
    else if (cp < 21'h00800) n = LEN_TWO;
    else if (cp < 21'h10000) n = LEN_THREE;
    else                     n = LEN_FOUR;
    return n;
  endfunction

  function automatic logic in_ws_list(input logic [CP_W-1:0] cp);
    return cp inside {[21'h00009:21'h0000D], 21'h00020, 21'h00085, 21'h000A0,
                      21'h01680, 21'h0180E, [21'h02000:21'h0200D], 21'h02028,
                      21'h02029, 21'h0202F, 21'h0205F, 21'h02060, 21'h03000,
                      21'h0FEFF};
  endfunction

endpackage

/* hw/rtl/utf8d_decode.sv */
// ----------------------------------------------------------------------------
// utf8d_decode
// Byte-wise UTF-8 decode state; flags each finished character.
// ----------------------------------------------------------------------------
module utf8d_decode (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [utf8d_pkg::BYTE_W-1:0] byte_in,
  output utf8d_pkg::char_t             chr
);

  logic [utf8d_pkg::REM_W-1:0] rem, rem_next;
  logic [utf8d_pkg::CP_W-1:0]  partial, partial_next;
  logic [utf8d_pkg::LEN_W-1:0] clen, clen_next;
  logic                        cont_ok, cont_ok_next;

  logic [utf8d_pkg::CP_W-1:0]  shifted;
  logic                        cok;

  always_comb begin
    shifted      = {partial[utf8d_pkg::CP_W-7:0], byte_in[5:0]};
    cok          = cont_ok & (byte_in[7:6] == 2'b10);
    rem_next     = rem;
    partial_next = partial;
    clen_next    = clen;
    cont_ok_next = cont_ok;
    chr          = '0;
    chr.len      = utf8d_pkg::LEN_ONE;
    chr.cont_ok  = 1'b1;

    if (rem == '0) begin
      case (utf8d_pkg::lead_kind(byte_in))
        utf8d_pkg::LEAD_ASCII: begin
          chr.emit   = 1'b1;
          chr.cp     = {{(utf8d_pkg::CP_W-utf8d_pkg::BYTE_W){1'b0}}, byte_in};
          chr.single = 1'b1;
        end
        utf8d_pkg::LEAD_TWO: begin
          partial_next = {16'd0, byte_in[4:0]};
          clen_next    = utf8d_pkg::LEN_TWO;
          rem_next     = 2'd1;
          cont_ok_next = 1'b1;
        end
        utf8d_pkg::LEAD_THREE: begin
          partial_next = {17'd0, byte_in[3:0]};
          clen_next    = utf8d_pkg::LEN_THREE;
          rem_next     = 2'd2;
          cont_ok_next = 1'b1;
        end
        utf8d_pkg::LEAD_FOUR: begin
          partial_next = {18'd0, byte_in[2:0]};
          clen_next    = utf8d_pkg::LEN_FOUR;
          rem_next     = 2'd3;
          cont_ok_next = 1'b1;
        end
        default: begin
          chr.emit = 1'b1;
          chr.bad  = 1'b1;
        end
      endcase
    end else begin
      rem_next     = rem - 2'd1;
      partial_next = shifted;
      cont_ok_next = cok;
      if (rem == 2'd1) begin
        chr.emit     = 1'b1;
        chr.cp       = shifted;
        chr.len      = clen;
        chr.cont_ok  = cok;
        partial_next = '0;
        clen_next    = '0;
        cont_ok_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem     <= '0;
      partial <= '0;
      clen    <= '0;
      cont_ok <= 1'b1;
    end else if (step) begin
      rem     <= rem_next;
      partial <= partial_next;
      clen    <= clen_next;
      cont_ok <= cont_ok_next;
    end
  end

endmodule

/* hw/rtl/utf8d_classify.sv */
// ----------------------------------------------------------------------------
// utf8d_classify
// Class flags of a finished character.
// ----------------------------------------------------------------------------
module utf8d_classify (
  input  utf8d_pkg::char_t   chr,
  output utf8d_pkg::result_t res
);

  logic [utf8d_pkg::BYTE_W-1:0] low;

  always_comb begin
    low       = chr.cp[utf8d_pkg::BYTE_W-1:0];
    res.cp    = chr.cp;
    res.len   = chr.len;
    res.bad   = chr.bad;
    res.ascii = chr.single;
    res.latin = chr.single && (low inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    res.digit = chr.single && (low inside {[8'h30:8'h39]});
    // whitespace only at its canonical encoding
    res.ws    = !chr.bad && chr.cont_ok
                && (utf8d_pkg::shortest_len(chr.cp) == chr.len)
                && utf8d_pkg::in_ws_list(chr.cp);
  end

endmodule

/* hw/rtl/utf8_decoder_classifier.sv */
// ----------------------------------------------------------------------------
// utf8_decoder_classifier
// UTF-8 byte stream decoder with per-character class flags.
// ----------------------------------------------------------------------------
// Usage
//   Slave side (s_*): one raw byte of the UTF-8 stream per transaction.
//   Master side (m_*): one transaction per finished character, or one per
//   illegal lead byte (code point 0, byte count 1, bad_lead set). Bytes that
//   are not the last of a multi-byte character produce no transaction.
//   Continuation bytes are not rejected; their low six bits are always used, and a bad one only clears is_whitespace.
//   A taken byte enters the input register; when it moves on, it is
//   decoded and classified and its result enters the result register,
//   which drives m_tvalid. Throughput: one byte per clock while the result
//   register is free or being emptied. The path is an input register, the
//   decode state update and classifier, then the result register.
//   Reset (rst, synchronous): empties both registers and returns the decoder
//   to expecting a lead byte.
//   Stall: while m_tready is low the result register holds its transaction;
//   the input register still drains into it once it is taken, and s_tready
//   falls only when both registers are full.
// ----------------------------------------------------------------------------
module utf8_decoder_classifier (
  input  logic                          clk,
  input  logic                          rst,
  // slave side
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [utf8d_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] byte_in
  // master side
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [utf8d_pkg::TDATA_W-1:0] m_tdata,   // [20:0] code_point, [23:21] byte_count
  output logic [utf8d_pkg::TUSER_W-1:0] m_tuser    // [0] is_whitespace, [1] is_ascii,
                                                   // [2] is_latin, [3] is_digit, [4] bad_lead
);

  // input register
  logic                         in_valid;
  logic [utf8d_pkg::BYTE_W-1:0] in_byte;
  logic                         advance;

  // result register
  logic                         out_valid;
  utf8d_pkg::result_t           out_res;

  utf8d_pkg::char_t             chr;
  utf8d_pkg::result_t           res;

  // the byte moves on whenever the result slot is free or being emptied
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  utf8d_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .byte_in (in_byte),
    .chr     (chr)
  );

  utf8d_classify u_classify (
    .chr (chr),
    .res (res)
  );

  // a byte without a result still clears a taken transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= chr.emit;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && chr.emit) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.len, out_res.cp};
  assign m_tuser  = {out_res.bad, out_res.digit, out_res.latin, out_res.ascii, out_res.ws};

  // ---- assertions ----
  // an illegal lead byte carries code point 0, length 1 and no class flags
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[4] |-> m_tdata == 24'h200000 && m_tuser[3:0] == 4'b0000)
    else $error("bad lead result malformed");

  // latin and digit are one-byte classes
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2] || m_tuser[3]) |-> m_tuser[1] && m_tdata[23:21] == 3'd1)
    else $error("latin or digit without ascii");

  // a multi-byte character is never ascii and never a bad lead
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[23:21] != 3'd1 |-> !m_tuser[1] && !m_tuser[4])
    else $error("multi-byte flags wrong");

  // ascii results keep a code point below 0x80
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata[20:7] == 14'd0)
    else $error("ascii code point out of range");

  // nothing is offered in the cycle after reset
  assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result offered after reset");

endmodule
